// File: rtl/pcje_pkg.sv
package pcje_pkg;

  localparam int IDX_W = 3;
  localparam int RES_W = 35;   // residues of 2*pi in Q32
  localparam int Z_W   = 36;   // signed angle, 32 fraction bits
  localparam int X_W   = 33;   // CORDIC x/y, 30 fraction bits
  localparam int ERR_W = 36;   // position error before the spring gain

  localparam longint PI_Q32         = 64'sd13493037705;
  localparam longint TWO_PI_Q32     = 64'sd26986075409;
  localparam longint HALF_PI_Q32    = 64'sd6746518852;
  localparam longint QUARTER_PI_Q32 = 64'sd3373259426;
  localparam longint GAIN_Q30       = 64'sd652032874;

  typedef enum logic [IDX_W-1:0] {
    REG_ANCHOR_X  = 3'd0,
    REG_ANCHOR_Y  = 3'd1,
    REG_TARGET_X  = 3'd2,
    REG_TARGET_Y  = 3'd3,
    REG_STIFFNESS = 3'd4,
    REG_DAMPING   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] dx_dangle;
    logic signed [31:0] dy_dangle;
    logic signed [31:0] d2x_dangle2;
    logic signed [31:0] d2y_dangle2;
    logic signed [31:0] spring_x;
    logic signed [31:0] spring_y;
    logic [30:0]        damping_out;
  } result_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic                  flip;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] d2x;
    logic signed [31:0] d2y;
  } deriv_t;

  // 2^n mod 2*pi (Q32), by repeated doubling
  function automatic logic [RES_W-1:0] residue_q32(input int n);
    longint r;
    r = 1;
    for (int k = 0; k < n; k++) begin
      r = r * 2;
      if (r >= TWO_PI_Q32) r = r - TWO_PI_Q32;
    end
    return r[RES_W-1:0];
  endfunction

  // quotient of two non-negative values by shift and subtract; builds constants only
  function automatic longint quot_q(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((num >>> b) & longint'(1));
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | longint'(1);
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q32 from the integer arctan series
  function automatic logic signed [Z_W-1:0] atan_q32(input int i);
    longint sum;
    longint term;
    longint t;
    int     k;
    sum = 0;
    k = 0;
    if (i == 0) return QUARTER_PI_Q32[Z_W-1:0];
    while (i * (2 * k + 1) <= 62) begin
      term = quot_q(longint'(1) << (62 - i * (2 * k + 1)), longint'(2 * k + 1));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      k++;
    end
    t = (sum + (longint'(1) << 29)) >>> 30;
    return t[Z_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ERR_W-1:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// File: rtl/pcje_cordic_stage.sv
module pcje_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  pcje_pkg::cordic_t d,
  output pcje_pkg::cordic_t q
);
  import pcje_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_q32(IDX);

  cordic_t n;

  always_comb begin
    n = d;
    if (d.z >= 0) begin
      n.x = d.x - ($signed(d.y) >>> IDX);
      n.y = d.y + ($signed(d.x) >>> IDX);
      n.z = d.z - ATAN;
    end else begin
      n.x = d.x + ($signed(d.y) >>> IDX);
      n.y = d.y - ($signed(d.x) >>> IDX);
      n.z = d.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= n;
  end

endmodule

// File: rtl/pcje_spring.sv
module pcje_spring #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [pcje_pkg::ERR_W-1:0] err,
  input  logic [30:0]                       gain,
  output logic signed [31:0]                q
);
  import pcje_pkg::*;

  localparam int SUM_W = 68;
  localparam int MAG_W = SUM_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic [ERR_W-1:0] mag_e;
  logic             neg1, neg2;
  logic [47:0]      plo;
  logic [49:0]      phi;
  logic [SUM_W-1:0] sum;
  logic [MAG_W-1:0] mag;

  assign mag_e = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
  assign sum   = (SUM_W'(phi) << 17) + SUM_W'(plo) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      // split the magnitude to keep each product narrow
      neg1 <= (err < 0);
      plo  <= 48'(gain) * 48'(mag_e[16:0]);
      phi  <= 50'(gain) * 50'(mag_e[ERR_W-1:17]);
      neg2 <= neg1;
      mag  <= MAG_W'(sum >> FRAC_BITS);
      if (neg2) begin
        q <= (mag > MAG_W'(64'd2147483648)) ? 32'sh80000000 : -$signed(mag[31:0]);
      end else begin
        q <= (mag > MAG_W'(64'd2147483647)) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
      end
    end
  end

endmodule

// File: rtl/pin_constraint_jacobian_eval.sv
// Pin constraint evaluator for one rigid body.
//
// Pose channel: pose_valid / pose_stall / pose carry one item (x, y, angle,
// Q16.16). Result channel: result_valid / result_stall / result carry the
// angle derivatives of the anchor, the spring terms and the damping gain.
// The write port (wr_en, wr_index, wr_data) sets anchor, target, stiffness
// and damping; write it only while no item is in flight.
//
// Five stages reduce the angle modulo two pi, one stage per CORDIC
// iteration follows, three stages rotate the anchor and form the errors,
// three more apply the spring gain. One item enters per cycle while the
// pipe is not stalled.
//
// Reset clears every valid bit and loads the register defaults (stiffness
// 10.0, damping 1.0, the rest zero). When the receiver stalls a valid result,
// the whole pipe holds and pose_stall rises in the same cycle; nothing is
// dropped or repeated.
module pin_constraint_jacobian_eval #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pose_valid,
  output logic                          pose_stall,
  input  pcje_pkg::pose_t               pose,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pcje_pkg::result_t             result,
  input  logic                          wr_en,
  input  logic [pcje_pkg::IDX_W-1:0]    wr_index,
  input  logic [31:0]                   wr_data
);
  import pcje_pkg::*;

  localparam int SHIFT = 32 - FRAC_BITS;
  localparam int LAT   = CORDIC_STEPS + 11;
  localparam logic [30:0] STIFF_RST = 31'(10) << FRAC_BITS;
  localparam logic [30:0] DAMP_RST  = 31'(1) << FRAC_BITS;

  localparam logic [39:0] M1  = 40'(TWO_PI_Q32);
  localparam logic [39:0] M2  = M1 << 1;
  localparam logic [39:0] M4  = M1 << 2;
  localparam logic [39:0] M8  = M1 << 3;
  localparam logic [39:0] M16 = M1 << 4;

  localparam logic signed [Z_W-1:0] PI_Z   = Z_W'(PI_Q32);
  localparam logic signed [Z_W-1:0] TPI_Z  = Z_W'(TWO_PI_Q32);
  localparam logic signed [Z_W-1:0] HPI_Z  = Z_W'(HALF_PI_Q32);
  localparam logic signed [X_W-1:0] GAIN_X = X_W'(GAIN_Q30);

  // configuration registers
  logic signed [31:0] anchor_x, anchor_y, target_x, target_y;
  logic [30:0]        stiffness, damping;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x  <= '0;
      anchor_y  <= '0;
      target_x  <= '0;
      target_y  <= '0;
      stiffness <= STIFF_RST;
      damping   <= DAMP_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ANCHOR_X:  anchor_x  <= $signed(wr_data);
        REG_ANCHOR_Y:  anchor_y  <= $signed(wr_data);
        REG_TARGET_X:  target_x  <= $signed(wr_data);
        REG_TARGET_Y:  target_y  <= $signed(wr_data);
        REG_STIFFNESS: stiffness <= wr_data[30:0];
        REG_DAMPING:   damping   <= wr_data[30:0];
        default: ;
      endcase
    end
  end

  // pipe control: advance unless a finished result is held by the receiver
  logic [LAT-1:0] vld;
  logic           adv;

  assign adv          = !(vld[LAT-1] && result_stall);
  assign pose_stall   = vld[LAT-1] && result_stall;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], pose_valid};
  end

  // stage 1: residue of each angle bit's weight, summed in groups of four
  logic [RES_W-1:0] term [32];
  logic [36:0]      g1 [8];
  logic [36:0]      r1_sum [8];
  logic signed [31:0] r1_px, r1_py;

  for (genvar j = 0; j < 32; j++) begin : g_res
    localparam longint RP = longint'(residue_q32(j + SHIFT));
    // sign bit weighs -2^(31+SHIFT): take the complement residue
    localparam logic [RES_W-1:0] RW = (j == 31) ? RES_W'(TWO_PI_Q32 - RP) : RES_W'(RP);
    assign term[j] = pose.angle[j] ? RW : '0;
  end

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      g1[g] = 37'(term[4*g]) + 37'(term[4*g+1]) + 37'(term[4*g+2]) + 37'(term[4*g+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_sum <= g1;
      r1_px  <= pose.pos_x;
      r1_py  <= pose.pos_y;
    end
  end

  // stage 2: total residue sum, below 32 * 2pi
  logic [39:0]        r2_sum;
  logic signed [31:0] r2_px, r2_py;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_sum <= ((40'(r1_sum[0]) + 40'(r1_sum[1])) + (40'(r1_sum[2]) + 40'(r1_sum[3])))
              + ((40'(r1_sum[4]) + 40'(r1_sum[5])) + (40'(r1_sum[6]) + 40'(r1_sum[7])));
      r2_px  <= r1_px;
      r2_py  <= r1_py;
    end
  end

  // stage 3: drop 16 and 8 multiples of 2pi
  logic [39:0]        s3a, s3b;
  logic [37:0]        r3_sum;
  logic signed [31:0] r3_px, r3_py;

  always_comb begin
    s3a = (r2_sum >= M16) ? r2_sum - M16 : r2_sum;
    s3b = (s3a >= M8) ? s3a - M8 : s3a;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_sum <= s3b[37:0];
      r3_px  <= r2_px;
      r3_py  <= r2_py;
    end
  end

  // stage 4: drop 4, 2 and 1 multiples, leaving [0, 2pi)
  logic [39:0]        s4a, s4b, s4c;
  logic [RES_W-1:0]   r4_z;
  logic signed [31:0] r4_px, r4_py;

  always_comb begin
    s4a = (40'(r3_sum) >= M4) ? 40'(r3_sum) - M4 : 40'(r3_sum);
    s4b = (s4a >= M2) ? s4a - M2 : s4a;
    s4c = (s4b >= M1) ? s4b - M1 : s4b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_z  <= s4c[RES_W-1:0];
      r4_px <= r3_px;
      r4_py <= r3_py;
    end
  end

  // stage 5: map to (-pi, pi], fold into [-pi/2, pi/2] and seed the CORDIC
  logic signed [Z_W-1:0] zc, zf;
  logic                  flip;
  cordic_t               cs [CORDIC_STEPS+1];

  always_comb begin
    zc = $signed({1'b0, r4_z});
    if (zc > PI_Z) zc = zc - TPI_Z;
    flip = 1'b0;
    zf   = zc;
    if (zc > HPI_Z) begin
      zf   = zc - PI_Z;
      flip = 1'b1;
    end else if (zc < -HPI_Z) begin
      zf   = zc + PI_Z;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0].x     <= GAIN_X;
      cs[0].y     <= '0;
      cs[0].z     <= zf;
      cs[0].flip  <= flip;
      cs[0].pos_x <= r4_px;
      cs[0].pos_y <= r4_py;
    end
  end

  // one register stage per CORDIC iteration
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    pcje_cordic_stage #(.IDX(i)) u_stage (
      .clk (clk),
      .en  (adv),
      .d   (cs[i]),
      .q   (cs[i+1])
    );
  end

  // M1: undo the fold, rotate the anchor (four products)
  cordic_t            cf;
  logic signed [31:0] cc, ss;
  logic signed [63:0] p_cx, p_sy, p_sx, p_cy;
  logic signed [31:0] m1_px, m1_py;

  assign cf = cs[CORDIC_STEPS];
  assign cc = cf.flip ? 32'(-cf.x) : 32'(cf.x);
  assign ss = cf.flip ? 32'(-cf.y) : 32'(cf.y);

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cx  <= cc * anchor_x;
      p_sy  <= ss * anchor_y;
      p_sx  <= ss * anchor_x;
      p_cy  <= cc * anchor_y;
      m1_px <= cf.pos_x;
      m1_py <= cf.pos_y;
    end
  end

  // M2: combine and round half up to FRAC_BITS
  logic signed [63:0] a_full, b_full;
  logic signed [33:0] m2_a, m2_b;
  logic signed [31:0] m2_px, m2_py;

  assign a_full = p_cx - p_sy + 64'sd536870912;
  assign b_full = p_sx + p_cy + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_a  <= 34'(a_full >>> 30);
      m2_b  <= 34'(b_full >>> 30);
      m2_px <= m1_px;
      m2_py <= m1_py;
    end
  end

  // M3: position errors and saturated derivatives
  logic signed [ERR_W-1:0] m3_ex, m3_ey;
  deriv_t                  dv, dly [3];

  always_comb begin
    dv.dx  = sat32(-ERR_W'(m2_b));
    dv.dy  = sat32(ERR_W'(m2_a));
    dv.d2x = sat32(-ERR_W'(m2_a));
    dv.d2y = sat32(-ERR_W'(m2_b));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_ex  <= ERR_W'(m2_px) + ERR_W'(m2_a) - ERR_W'(target_x);
      m3_ey  <= ERR_W'(m2_py) + ERR_W'(m2_b) - ERR_W'(target_y);
      dly[0] <= dv;
      // hold derivatives alongside the three spring stages
      dly[1] <= dly[0];
      dly[2] <= dly[1];
    end
  end

  logic signed [31:0] spx, spy;

  pcje_spring #(.FRAC_BITS(FRAC_BITS)) u_spring_x (
    .clk  (clk),
    .en   (adv),
    .err  (m3_ex),
    .gain (stiffness),
    .q    (spx)
  );

  pcje_spring #(.FRAC_BITS(FRAC_BITS)) u_spring_y (
    .clk  (clk),
    .en   (adv),
    .err  (m3_ey),
    .gain (stiffness),
    .q    (spy)
  );

  deriv_t dq;

  // last derivative stage lines up with the spring output registers
  always_ff @(posedge clk) begin
    if (adv) dq <= dly[2];
  end

  always_comb begin
    result.dx_dangle   = dq.dx;
    result.dy_dangle   = dq.dy;
    result.d2x_dangle2 = dq.d2x;
    result.d2y_dangle2 = dq.d2y;
    result.spring_x    = spx;
    result.spring_y    = spy;
    result.damping_out = damping;
  end

endmodule

// File: rtl/pcje_checker.sv
module pcje_checker (
  input logic              clk,
  input logic              rst,
  input logic              pose_valid,
  input logic              pose_stall,
  input logic              result_valid,
  input logic              result_stall,
  input pcje_pkg::result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_same_term: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.d2y_dangle2 == result.dx_dangle)
    else $error("d2y_dangle2 differs from dx_dangle");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pose_stall |-> result_valid && result_stall)
    else $error("pose stalled without a held result");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !pose_valid && !result_valid |-> !pose_stall)
    else $error("stall raised with nothing in flight at output");

endmodule

bind pin_constraint_jacobian_eval pcje_checker u_pcje_checker (
  .clk          (clk),
  .rst          (rst),
  .pose_valid   (pose_valid),
  .pose_stall   (pose_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
